### sv/bba_pkg.sv
// ============================================================================
// bba_pkg: shared types and codes of the bitmap block allocator
// Request and response payloads, request kinds, status codes and the fixed
// field widths.
// ============================================================================
package bba_pkg;

    localparam int CNT_W  = 11;             // block counts, 0..2047
    localparam int IDX_W  = 10;             // block index on the ports
    localparam int WORD_W = 32;             // bitmap bits per memory word
    localparam int BIT_W  = 5;              // bit position within a word
    localparam int WIDX_W = CNT_W - BIT_W;  // word number below any bound

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

    // Request kinds
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_MARK    = 2'd2;
    localparam logic [1:0] REQ_CHECK   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] needed_blocks;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_block;
        logic             enough_free;
        logic [CNT_W-1:0] free_blocks;
    } rsp_t;

endpackage

### sv/bba_map_ram.sv
// ============================================================================
// bba_map_ram: bitmap word store
// Single write port, single read port, read data registered.
// ============================================================================
module bba_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/bitmap_block_allocator_core.sv
// ============================================================================
// bitmap_block_allocator_core: used/free bitmap over storage blocks
// Release, mark-used and check: the request is registered, then executed
// against the bitmap word read for it; one request at a time, the next is
// taken once the result has moved into the output register.
// Allocate: the scan reads bitmap words one per cycle, up to ceil(bound/32),
// 32 at the default bound, over the single read port of the bitmap memory.
// Reset and every block_count write: clearing pass over ceil(bound/32)
// words (at least one) before the first item is taken.
// ============================================================================
module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bba_pkg::req_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bba_pkg::rsp_t              out_data,
    input  logic                       cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]  cfg_wdata
);

    import bba_pkg::*;

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [CNT_W-1:0] BOUND_RESET =
        CNT_W'((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    // Lowest set bit of a word: isolate it, then encode the one-hot.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] one_hot;
        logic [BIT_W-1:0]  pos;
        one_hot = v & (~v + WORD_W'(1));
        pos     = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            pos = pos | (one_hot[j] ? BIT_W'(j) : '0);
        end
        return pos;
    endfunction

    state_t            state_reg;
    req_t              req_reg;
    rsp_t              res_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;
    logic [WIDX_W-1:0] word_reg;
    logic [WIDX_W-1:0] clear_reg;
    logic [CNT_W-1:0]  bound_reg;
    logic [CNT_W-1:0]  free_reg;

    // Bitmap memory ports
    logic              wr_en;
    logic [WIDX_W-1:0] wr_word;
    logic [WORD_W-1:0] wr_data;
    logic [WIDX_W-1:0] rd_word;
    logic [WORD_W-1:0] rd_data;

    // Bound and word bookkeeping
    logic [CNT_W-1:0]  bound_next;
    logic [CNT_W-1:0]  bound_m1;
    logic [WIDX_W-1:0] last_word;
    logic [WIDX_W-1:0] in_word;

    // Execute-stage datapath
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] pick_bit;
    logic [BIT_W-1:0]  pick_pos;
    logic [WORD_W-1:0] idx_bit;
    logic              idx_in_range;
    logic              idx_used;
    logic              done;
    logic [CNT_W-1:0]  free_next;
    logic [CNT_W-1:0]  granted_full;
    rsp_t              res_next;

    // Output register load: a finished result moves in when the register is free.
    logic              out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == S_OUT) && !cfg_we && (!out_valid_reg || out_ready);

    // Active bound saturates at the size of the map.
    assign bound_next = (32'(cfg_wdata) < NUM_BLOCKS) ? cfg_wdata : CNT_W'(NUM_BLOCKS);

    // Last word that holds a block below the bound; word zero when the bound is zero.
    assign bound_m1  = bound_reg - CNT_W'(1);
    assign last_word = (bound_reg == '0) ? '0 : bound_m1[CNT_W-1:BIT_W];
    assign in_word   = WIDX_W'(in_data.block_index[IDX_W-1:BIT_W]);

    // Read address: the first word of a new request, else the next scan word.
    always_comb
    begin
        rd_word = word_reg;
        if (state_reg == S_IDLE)
        begin
            rd_word = (in_data.req_type == REQ_ALLOC) ? '0 : in_word;
        end
        else if (state_reg == S_EXEC)
        begin
            rd_word = word_reg + WIDX_W'(1);
        end
    end

    // Mask off bits at or above the bound in the word being scanned.
    always_comb
    begin
        if (word_reg < bound_reg[CNT_W-1:BIT_W])
        begin
            valid_mask = '1;
        end
        else if (word_reg == bound_reg[CNT_W-1:BIT_W])
        begin
            valid_mask = (WORD_W'(1) << bound_reg[BIT_W-1:0]) - WORD_W'(1);
        end
        else
        begin
            valid_mask = '0;
        end
    end

    assign free_bits    = ~rd_data & valid_mask;
    assign pick_bit     = free_bits & (~free_bits + WORD_W'(1));
    assign pick_pos     = lowest_set(free_bits);
    assign granted_full = {word_reg, pick_pos};

    assign idx_bit      = WORD_W'(1) << req_reg.block_index[BIT_W-1:0];
    assign idx_in_range = ({1'b0, req_reg.block_index} < bound_reg);
    assign idx_used     = |(rd_data & idx_bit);

    // Clearing pass: zero one word; else execute one step of the current request against the word just read.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_word   = word_reg;
        wr_data   = rd_data;
        free_next = free_reg;
        done      = 1'b1;
        res_next  = '0;
        res_next.status = STAT_OK;

        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_word = clear_reg;
            wr_data = '0;
        end
        else if (state_reg == S_EXEC)
        begin
            case (req_reg.req_type)
                REQ_ALLOC:
                begin
                    if (bound_reg == '0)
                    begin
                        res_next.status = STAT_NO_FREE;
                    end
                    else if (|free_bits)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = rd_data | pick_bit;
                        free_next = free_reg - CNT_W'(1);
                        res_next.granted_block = granted_full[IDX_W-1:0];
                    end
                    else if (word_reg != last_word)
                    begin
                        done = 1'b0;
                    end
                    else
                    begin
                        res_next.status = STAT_NO_FREE;
                    end
                end
                REQ_RELEASE, REQ_MARK:
                begin
                    if (!idx_in_range)
                    begin
                        res_next.status = STAT_RANGE;
                    end
                    else if (req_reg.req_type == REQ_RELEASE)
                    begin
                        if (idx_used)
                        begin
                            wr_en     = 1'b1;
                            wr_data   = rd_data & ~idx_bit;
                            free_next = free_reg + CNT_W'(1);
                        end
                    end
                    else if (!idx_used)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = rd_data | idx_bit;
                        free_next = free_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    res_next.enough_free = (free_reg >= req_reg.needed_blocks);
                end
            endcase
        end

        res_next.free_blocks = free_next;
    end

    bba_map_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (WAW),
        .DW    (WORD_W)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (WAW'(wr_word)),
        .wr_data (wr_data),
        .rd_addr (WAW'(rd_word)),
        .rd_data (rd_data)
    );

    // Sequencer: clearing pass, request intake, scan / read-modify-write,
    // result hand-off to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_reg     <= '0;
            word_reg      <= '0;
            bound_reg     <= BOUND_RESET;
            free_reg      <= BOUND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Refill the output on a load; otherwise drop it once it is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                // Reformat: new bound, all blocks free, sweep the map again.
                bound_reg <= bound_next;
                free_reg  <= bound_next;
                clear_reg <= '0;
                state_reg <= S_CLEAR;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        if (clear_reg == last_word)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            clear_reg <= clear_reg + WIDX_W'(1);
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            req_reg   <= in_data;
                            word_reg  <= rd_word;
                            state_reg <= S_EXEC;
                        end
                    end
                    S_EXEC:
                    begin
                        free_reg <= free_next;
                        if (done)
                        begin
                            res_reg   <= res_next;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            // Advance the scan; the next word's read is already issued.
                            word_reg <= word_reg + WIDX_W'(1);
                        end
                    end
                    S_OUT:
                    begin
                        // Hold the result until the output register is free.
                        if (out_load)
                        begin
                            out_reg   <= res_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

### sv/bba_checker.sv
// ============================================================================
// bba_checker: port-level checks of the bitmap block allocator
// Watches the request and result ports over time.
// ============================================================================
module bba_checker #(
    parameter int NUM_BLOCKS = 1024
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input bba_pkg::rsp_t             out_data
);

    import bba_pkg::*;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One request at a time: no transfer in the cycle after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // Failed requests grant nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STAT_OK) |-> out_data.granted_block == '0)
        else $error("granted block on a failed request");

    // Only a check that succeeds reports enough free blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.enough_free |-> out_data.status == STAT_OK)
        else $error("enough_free with a failure status");

    // The free count never exceeds the map size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.free_blocks) <= NUM_BLOCKS)
        else $error("free count above map size");

endmodule

bind bitmap_block_allocator_core bba_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### verif/tb_bitmap_block_allocator_core.sv
// ============================================================================
// tb_bitmap_block_allocator_core: self-checking bench for the block allocator
// Drive allocate, release, mark-used and check requests over valid/ready,
// predict every response from a bit-level copy of the bitmap and free count,
// and compare each response transfer field by field, in order. Cover the
// block_count extremes (zero, one, exact and saturated bound), random gaps
// on both sides, a long output stall and drained pauses on the input side.
// ============================================================================
module tb_bitmap_block_allocator_core;
    import bba_pkg::*;

    localparam int NUM_BLOCKS   = 1024;
    // Drain margin: the longest allocate scan at the full bound reads all 32 bitmap words.
    localparam int DRAIN_CYCLES = 40;
    // Output hold-off long enough to fill the block and stall its input.
    localparam int HOLD_CYCLES  = 300;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    req_t             in_data;
    logic             out_valid;
    logic             out_ready;
    rsp_t             out_data;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bitmap_block_allocator_core #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predicted allocator state: one bit per block, the free count and
    // the programmed block_count.
    // ------------------------------------------------------------------
    bit               used_bits [NUM_BLOCKS];
    int unsigned      free_count;
    logic [CNT_W-1:0] block_count_reg;

    // Responses still owed by the block, oldest first.
    rsp_t             pending_rsp_q [$];
    int               error_count;

    // Traffic shaping shared by the tests and the two channel processes.
    bit               tx_no_gap;
    bit               rx_no_stall;
    int               rx_stall_left;
    int               rx_hold_request;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Saturate block_count at the bitmap size.
    function automatic int unsigned active_bound();
        return (block_count_reg < NUM_BLOCKS) ? int'(block_count_reg) : NUM_BLOCKS;
    endfunction

    // Reformat: every block free, count back to the bound.
    function automatic void format_bitmap();
        foreach (used_bits[i])
            used_bits[i] = 1'b0;
        free_count = active_bound();
    endfunction

    // Apply one request to the predicted state and return its response.
    function automatic rsp_t apply_request(req_t r);
        rsp_t        rsp;
        int unsigned lim;
        int unsigned i;
        lim = active_bound();
        rsp = '0;
        rsp.status = STAT_OK;
        case (r.req_type)
            REQ_ALLOC:
            begin
                // Lowest free block below the bound wins.
                i = 0;
                while (i < lim && used_bits[i])
                    i++;
                if (i < lim)
                begin
                    used_bits[i] = 1'b1;
                    free_count--;
                    rsp.granted_block = IDX_W'(i);
                end
                else
                    rsp.status = STAT_NO_FREE;
            end
            REQ_RELEASE, REQ_MARK:
            begin
                if (r.block_index >= lim)
                    rsp.status = STAT_RANGE;
                else if (r.req_type == REQ_RELEASE)
                begin
                    // Count moves only when the bit actually flips.
                    if (used_bits[r.block_index])
                    begin
                        used_bits[r.block_index] = 1'b0;
                        free_count++;
                    end
                end
                else if (!used_bits[r.block_index])
                begin
                    used_bits[r.block_index] = 1'b1;
                    free_count--;
                end
            end
            default:
                rsp.enough_free = (free_count >= r.needed_blocks);
        endcase
        rsp.free_blocks = CNT_W'(free_count);
        return rsp;
    endfunction

    function automatic req_t make_request(logic [1:0] kind, int unsigned idx,
                                          int unsigned need);
        req_t r;
        r.req_type      = kind;
        r.block_index   = IDX_W'(idx);
        r.needed_blocks = CNT_W'(need);
        return r;
    endfunction

    // Random request with every field random; steer indices toward the
    // populated low end of the map and check thresholds toward the count.
    function automatic req_t build_random_request();
        req_t        r;
        int unsigned lim;
        int unsigned pick;
        int          n;
        lim             = active_bound();
        r.block_index   = IDX_W'($urandom);
        r.needed_blocks = CNT_W'($urandom_range(0, 1024));
        pick            = $urandom_range(0, 99);
        if (pick < 35)
            r.req_type = REQ_ALLOC;
        else if (pick < 60)
            r.req_type = REQ_RELEASE;
        else if (pick < 75)
            r.req_type = REQ_MARK;
        else
            r.req_type = REQ_CHECK;
        if (r.req_type == REQ_RELEASE || r.req_type == REQ_MARK)
        begin
            case ($urandom_range(0, 7))
                0: ; // keep the raw index, often out of range on small bounds
                1: r.block_index = IDX_W'((lim < NUM_BLOCKS) ? lim : NUM_BLOCKS - 1);
                default:
                    if (lim > 0)
                        r.block_index = IDX_W'($urandom_range(0, ((lim < 64) ? lim : 64) - 1));
            endcase
        end
        else if (r.req_type == REQ_CHECK && $urandom_range(0, 1) == 1)
        begin
            // Hit the threshold just below, at and just above the count.
            n = int'(free_count) + int'($urandom_range(0, 2)) - 1;
            if (n < 0)
                n = 0;
            if (n > 1024)
                n = 1024;
            r.needed_blocks = CNT_W'(n);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one request after a random gap, hold it until the
    // transfer, then record the predicted response.
    // ------------------------------------------------------------------
    task automatic send_request(input req_t r);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        pending_rsp_q.push_back(apply_request(r));
    endtask

    // Drop valid and wait until every owed response has been taken.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Write block_count only with the block idle; the model reformats too.
    task automatic write_block_count(input logic [CNT_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        block_count_reg = value;
        format_bitmap();
    endtask

    // ------------------------------------------------------------------
    // Output side. The driver counts down stall cycles at the falling
    // edge; a long hold request from a test overrides the random stall.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_hold_request > 0)
            begin
                rx_stall_left   = rx_hold_request;
                rx_hold_request = 0;
            end
            out_ready <= (rx_stall_left == 0);
            if (rx_stall_left > 0)
                rx_stall_left--;
        end
    end

    // Check each response transfer against the oldest prediction, then
    // draw the stall before the next one.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected response transfer: %h", out_data);
                error_count++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    error_count++;
                end
                if (out_data.granted_block !== want.granted_block)
                begin
                    $error("granted_block: expected %0d, actual %0d",
                           want.granted_block, out_data.granted_block);
                    error_count++;
                end
                if (out_data.enough_free !== want.enough_free)
                begin
                    $error("enough_free: expected %0d, actual %0d",
                           want.enough_free, out_data.enough_free);
                    error_count++;
                end
                if (out_data.free_blocks !== want.free_blocks)
                begin
                    $error("free_blocks: expected %0d, actual %0d",
                           want.free_blocks, out_data.free_blocks);
                    error_count++;
                end
            end
            rx_stall_left = rx_no_stall ? 0 : $urandom_range(0, 5);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every request kind at the reset bound of 1024 blocks.
    task automatic test_directed_requests();
        send_request(make_request(REQ_ALLOC,   1023, 1024)); // block 0
        send_request(make_request(REQ_ALLOC,   0,    0));    // block 1
        send_request(make_request(REQ_CHECK,   1023, 0));
        send_request(make_request(REQ_CHECK,   0,    1024)); // not enough
        send_request(make_request(REQ_CHECK,   5,    1022)); // exactly enough
        send_request(make_request(REQ_MARK,    1023, 7));
        send_request(make_request(REQ_MARK,    1023, 7));    // already used
        send_request(make_request(REQ_RELEASE, 1023, 1023));
        send_request(make_request(REQ_RELEASE, 1023, 1023)); // already free
        send_request(make_request(REQ_RELEASE, 0,    0));    // hole at 0
        send_request(make_request(REQ_ALLOC,   512,  3));    // refill the hole
        send_request(make_request(REQ_MARK,    2,    0));
        send_request(make_request(REQ_ALLOC,   0,    0));    // skips 2
    endtask

    // Zero blocks, one block and a count above the bitmap size.
    task automatic test_bound_extremes();
        write_block_count(CNT_W'(0));
        send_request(make_request(REQ_ALLOC,   0,    0));    // nothing free
        send_request(make_request(REQ_RELEASE, 0,    0));    // out of range
        send_request(make_request(REQ_MARK,    1023, 0));    // out of range
        send_request(make_request(REQ_CHECK,   0,    0));
        send_request(make_request(REQ_CHECK,   0,    1));
        write_block_count(CNT_W'(1));
        send_request(make_request(REQ_ALLOC,   0,    0));
        send_request(make_request(REQ_ALLOC,   0,    0));    // map full
        send_request(make_request(REQ_MARK,    1,    0));    // index at bound
        send_request(make_request(REQ_RELEASE, 0,    0));
        send_request(make_request(REQ_CHECK,   0,    1));
        write_block_count(CNT_W'(2047));                     // saturates
        send_request(make_request(REQ_CHECK,   0,    1024));
        send_request(make_request(REQ_MARK,    1023, 0));
        send_request(make_request(REQ_RELEASE, 1023, 0));
        send_request(make_request(REQ_ALLOC,   0,    0));
    endtask

    // Random traffic over a spread of block counts; some phases run with
    // no gaps or no stalls at all.
    task automatic test_random_traffic();
        logic [CNT_W-1:0] value;
        int               n;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin value = CNT_W'(1024); n = 50; end
                1:       begin value = CNT_W'(2047); n = 30; end
                2:       begin value = CNT_W'(33);   n = 50; end
                3:       begin value = CNT_W'(32);   n = 30; end
                4:       begin value = CNT_W'($urandom_range(1, 64));   n = 40; end
                5:       begin value = CNT_W'(1);    n = 20; end
                6:       begin value = CNT_W'($urandom_range(1, 1024)); n = 50; end
                default: begin value = CNT_W'(8);    n = 30; end
            endcase
            write_block_count(value);
            tx_no_gap   = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            repeat (n) send_request(build_random_request());
        end
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // Hold the output off for a long stretch while requests keep coming
    // back to back, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        write_block_count(CNT_W'(48));
        rx_hold_request = HOLD_CYCLES;
        tx_no_gap       = 1'b1;
        repeat (40) send_request(build_random_request());
        tx_no_gap       = 1'b0;
        wait_for_drain();
    endtask

    // Short bursts, each followed by a full drain and an idle pause.
    task automatic test_sender_pause();
        write_block_count(CNT_W'(20));
        repeat (8)
        begin
            repeat ($urandom_range(1, 8)) send_request(build_random_request());
            wait_for_drain();
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        error_count     = 0;
        tx_no_gap       = 1'b0;
        rx_no_stall     = 1'b0;
        rx_stall_left   = 0;
        rx_hold_request = 0;
        block_count_reg = BLOCK_COUNT_RESET;
        format_bitmap();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_requests();
        test_bound_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        // Let any stray response show up before the verdict.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
